// ===== src/pressure_bar_peak_locator_assert.svh =====
// assertion macros for the peak locator
`ifndef PRESSURE_BAR_PEAK_LOCATOR_ASSERT_SVH
`define PRESSURE_BAR_PEAK_LOCATOR_ASSERT_SVH
`define PBPL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PBPL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

// ===== src/pbpl_pkg.sv =====
// shared types and constants of the peak locator
package pbpl_pkg;
    localparam int ValW = 24;
    localparam int SampW = 10;
    localparam logic [10:0] XMax = 11'd2047;
    localparam logic [14:0] YMax = 15'd24576;
    localparam logic [3:0] SlotLimit = 4'd8;
    localparam logic [1:0] RegNorm = 2'd0;
    localparam logic [1:0] RegRelease = 2'd1;
    localparam logic [1:0] RegAttack = 2'd2;
    localparam logic [1:0] RegMaxBlobs = 2'd3;
    localparam logic OpCalibrate = 1'b0;
    localparam logic OpMeasure = 1'b1;
    // ceil(2^29 / 3), exact floor(n / 3) for n below 2^29
    localparam logic [27:0] Recip3 = 28'hAAAAAAB;

    typedef struct packed {
        logic        operation;
        logic [9:0]  row0_sample;
        logic [9:0]  row1_sample;
        logic        last_bar;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  blob_slot;
        logic [10:0] x_position;
        logic [14:0] y_ratio;
        logic [23:0] z_pressure;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [23:0] data;
    } t_cfg_item;

    // queue entry between front and back
    typedef struct packed {
        logic        measure;
        logic        frame_end;
        logic [3:0]  bar;
        logic [9:0]  d0;
        logic [9:0]  d1;
    } t_task;
endpackage

// ===== src/pbpl_if.sv =====
// valid/ready channel interface
interface pbpl_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/pbpl_ram.sv =====
// generic single port ram with registered read
module pbpl_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/pbpl_front.sv =====
// front: bar counting, baseline store and difference
module pbpl_front #(
    parameter int NumBars = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pbpl_if.sink                in_ch,
    output logic                o_q_valid,
    output pbpl_pkg::t_task     o_q_data,
    input  logic                i_q_ready
);
    localparam int AW = $clog2(NumBars);
    localparam logic [3:0] LastIdx = 4'(NumBars - 1);

    logic [3:0]          r_bar, n_bar;
    logic                r_busy;
    pbpl_pkg::t_in_item  r_item;
    logic [3:0]          r_ibar;
    logic [19:0]         w_base;
    logic                w_acc, w_we;
    logic                r_hold;
    pbpl_pkg::t_task     r_task;

    assign in_ch.ready = !r_busy && !r_hold;
    assign w_acc = in_ch.valid && in_ch.ready;
    assign w_we = w_acc && in_ch.data.operation == pbpl_pkg::OpCalibrate;
    assign n_bar = (in_ch.data.last_bar || r_bar >= LastIdx) ? 4'd0 : r_bar + 4'd1;

    pbpl_ram #(.Width(20), .Depth(NumBars)) u_base (
        .i_clk(i_clk), .i_we(w_we), .i_addr(r_bar[AW-1:0]),
        .i_wdata({in_ch.data.row1_sample, in_ch.data.row0_sample}),
        .o_rdata(w_base));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar <= '0;
            r_busy <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            if (w_acc) begin
                r_bar <= n_bar;
                r_busy <= 1'b1;
                r_item <= in_ch.data;
                r_ibar <= r_bar;
            end
            if (r_busy) begin
                r_busy <= 1'b0;
                r_hold <= 1'b1;
                r_task.measure <= r_item.operation;
                r_task.frame_end <= r_item.last_bar || r_ibar >= LastIdx;
                r_task.bar <= r_ibar;
                r_task.d0 <= r_item.row0_sample > w_base[9:0] ?
                    r_item.row0_sample - w_base[9:0] : 10'd0;
                r_task.d1 <= r_item.row1_sample > w_base[19:10] ?
                    r_item.row1_sample - w_base[19:10] : 10'd0;
            end
            if (r_hold && i_q_ready) begin
                r_hold <= 1'b0;
            end
        end
    end
    assign o_q_valid = r_hold;
    assign o_q_data = r_task;
endmodule

// ===== src/pbpl_queue.sv =====
// two entry queue between front and back
module pbpl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pbpl_pkg::t_task i_data,
    output logic            o_ready,
    output logic            o_valid,
    output pbpl_pkg::t_task o_data,
    input  logic            i_ready
);
    pbpl_pkg::t_task r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== src/pbpl_div.sv =====
// shared restoring divider, one quotient bit a cycle
module pbpl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [39:0] i_den,
    output logic        o_done,
    output logic [39:0] o_quo
);
    logic [39:0] r_rem, r_quo, r_den;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [40:0] w_sh;
    assign w_sh = {r_rem, r_quo[39]};
    assign o_quo = r_quo;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
                r_cnt <= 6'd40;
            end else if (r_run) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= 40'(w_sh - {1'b0, r_den});
                    r_quo <= {r_quo[38:0], 1'b1};
                end else begin
                    r_rem <= w_sh[39:0];
                    r_quo <= {r_quo[38:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/pbpl_back.sv =====
// back: normalization, peak window and interpolation
module pbpl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  pbpl_pkg::t_task i_q_data,
    output logic            o_q_ready,
    input  logic [9:0]      i_norm,
    input  logic [23:0]     i_release,
    input  logic [23:0]     i_attack,
    input  logic [3:0]      i_max_blobs,
    pbpl_if.source          out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_V0, S_V1, S_PEAK, S_Z, S_X, S_Y, S_OUT, S_SHIFT
    } t_state;
    t_state r_state;
    pbpl_pkg::t_task r_t;
    logic [23:0] r_v0, r_v1, r_p0, r_p1, r_q0, r_q1;
    logic [3:0]  r_peaks;
    logic [25:0] r_a, r_b, r_c, r_row0;
    logic [23:0] r_z;
    logic [14:0] r_y;
    logic        r_neg;
    logic [7:0]  r_mag;
    logic        r_ov;
    pbpl_pkg::t_out_item r_out;
    logic        r_ostart;
    logic [39:0] r_num, r_den;
    logic        w_done;
    logic [39:0] w_quo;
    logic [23:0] w_val;
    logic [3:0]  w_lim;
    logic [11:0] w_x;
    logic [26:0] w_sum;
    logic [53:0] w_prod;

    pbpl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_ostart),
        .i_num(r_num), .i_den(r_den), .o_done(w_done), .o_quo(w_quo));

    assign w_val = (w_quo > 40'hFFFFFF) ? 24'hFFFFFF :
        ((w_quo[23:0] < i_release) ? 24'd0 : w_quo[23:0]);
    assign w_lim = i_max_blobs > pbpl_pkg::SlotLimit ? pbpl_pkg::SlotLimit : i_max_blobs;
    assign w_x = r_neg ? ({r_t.bar - 4'd1, 8'd0} - {4'd0, r_mag})
                       : ({r_t.bar - 4'd1, 8'd0} + {4'd0, r_mag});
    // mean over six: halve, then divide by three by reciprocal multiply
    assign w_sum = 27'(r_a) + 27'(r_b) + 27'(r_c);
    assign w_prod = w_sum[26:1] * pbpl_pkg::Recip3;
    assign o_q_ready = r_state == S_IDLE;
    assign out_ch.valid = r_ov;
    assign out_ch.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_ostart <= 1'b0;
            r_peaks <= '0;
            r_p0 <= '0; r_p1 <= '0; r_q0 <= '0; r_q1 <= '0;
        end else begin
            r_ostart <= 1'b0;
            if (r_ov && out_ch.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_q_valid) begin
                    r_t <= i_q_data;
                    r_v0 <= '0; r_v1 <= '0;
                    if (i_q_data.measure) begin
                        r_num <= {16'd0, i_q_data.d0, 14'd0};
                        r_den <= {30'd0, i_norm == 10'd0 ? 10'd1 : i_norm};
                        r_ostart <= 1'b1;
                        r_state <= S_V0;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_V0: if (w_done) begin
                    r_v0 <= w_val;
                    r_num <= {16'd0, r_t.d1, 14'd0};
                    r_ostart <= 1'b1;
                    r_state <= S_V1;
                end
                S_V1: if (w_done) begin
                    r_v1 <= w_val;
                    r_a <= 26'(r_q0) + 26'(r_q1);
                    r_b <= 26'(r_p0) + 26'(r_p1);
                    r_c <= 26'(r_v0) + 26'(w_val);
                    r_row0 <= 26'(r_q0) + 26'(r_p0) + 26'(r_v0);
                    r_state <= S_PEAK;
                end
                S_PEAK: begin
                    if (r_t.bar >= 4'd2 && r_a < r_b && r_b > r_c
                        && r_peaks < w_lim) begin
                        r_z <= w_prod[52:29];
                        r_state <= S_Z;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_Z: begin
                    if (r_z > i_attack) begin
                        r_neg <= r_c < r_a;
                        r_num <= {7'd0, (r_c >= r_a ? r_c - r_a : r_a - r_c), 7'd0};
                        r_den <= 40'(r_b - r_a) + 40'(r_b - r_c);
                        r_ostart <= 1'b1;
                        r_state <= S_X;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_X: if (w_done) begin
                    r_mag <= w_quo[7:0];
                    r_num <= {2'd0, r_row0, 12'd0};
                    r_den <= {16'd0, r_z};
                    r_ostart <= 1'b1;
                    r_state <= S_Y;
                end
                S_Y: if (w_done) begin
                    r_y <= w_quo > 40'(pbpl_pkg::YMax) ? pbpl_pkg::YMax : w_quo[14:0];
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ov) begin
                    r_out.blob_slot <= r_peaks[2:0];
                    r_out.x_position <= w_x[11] ? pbpl_pkg::XMax : w_x[10:0];
                    r_out.y_ratio <= r_y;
                    r_out.z_pressure <= r_z;
                    r_ov <= 1'b1;
                    r_peaks <= r_peaks + 4'd1;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_q0 <= r_p0; r_q1 <= r_p1;
                    r_p0 <= r_v0; r_p1 <= r_v1;
                    if (r_t.frame_end) r_peaks <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/pressure_bar_peak_locator.sv =====
// top level of the pressure bar peak locator
// One request is one bar. The front reads the baseline memory and subtracts,
// a two-entry queue decouples it from the back, which runs every variable
// division on one shared 40-step serial divider and takes the mean over six
// by a reciprocal multiply. A reported peak also waits for the previous
// result to be taken.
module pressure_bar_peak_locator #(
    parameter int NumBars = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pbpl_if.sink   in_ch,
    pbpl_if.sink   cfg_ch,
    pbpl_if.source out_ch
);
    logic [9:0]  r_norm;
    logic [23:0] r_release, r_attack;
    logic [3:0]  r_max;
    logic f_valid, f_ready, b_valid, b_ready;
    pbpl_pkg::t_task f_data, b_data;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= 10'd512;
            r_release <= 24'd49;
            r_attack <= 24'd115;
            r_max <= 4'd8;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.data.index)
                pbpl_pkg::RegNorm: r_norm <= cfg_ch.data.data[9:0];
                pbpl_pkg::RegRelease: r_release <= cfg_ch.data.data;
                pbpl_pkg::RegAttack: r_attack <= cfg_ch.data.data;
                pbpl_pkg::RegMaxBlobs: r_max <= cfg_ch.data.data[3:0];
                default: ;
            endcase
        end
    end

    pbpl_front #(.NumBars(NumBars)) u_front (.i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch), .o_q_valid(f_valid), .o_q_data(f_data), .i_q_ready(f_ready));
    pbpl_queue u_queue (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid),
        .i_data(f_data), .o_ready(f_ready), .o_valid(b_valid), .o_data(b_data),
        .i_ready(b_ready));
    pbpl_back u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(b_valid),
        .i_q_data(b_data), .o_q_ready(b_ready), .i_norm(r_norm),
        .i_release(r_release), .i_attack(r_attack), .i_max_blobs(r_max),
        .out_ch(out_ch));
endmodule

// ===== src/pbpl_checker.sv =====
// port level checks of the peak locator
`include "pressure_bar_peak_locator_assert.svh"
module pbpl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input pbpl_pkg::t_out_item o_data
);
    `PBPL_ASSERT(a_hold, o_valid && !i_ready |=> o_valid && $stable(o_data), "result dropped")
    `PBPL_ASSERT(a_y, o_valid |-> o_data.y_ratio <= pbpl_pkg::YMax, "y over range")
    `PBPL_ASSERT_RST(a_rst, !i_rst_n |=> !o_valid, "result after reset")
endmodule

bind pressure_bar_peak_locator pbpl_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_data(out_ch.data));
